FILE: src/dfr_pkg.sv
// Shared types and constants for the length-prefixed deframer.
`default_nettype none
package dfr_pkg;

  // Width of the length counters; lengths wrap modulo 2**LEN_W
  localparam int unsigned LEN_W = 32;

  // ASCII characters used by the parser
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // Result kinds
  localparam logic [1:0] KIND_NAME   = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;
  localparam logic [1:0] KIND_CLOSED = 2'd3;

  // Input beat
  typedef struct packed {
    logic [7:0] in_byte;
    logic       link_closed;
  } dfr_in_t;

  // Result beat
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;
  } dfr_out_t;

endpackage
`default_nettype wire

FILE: src/dfr_in_stage.sv
// Input register: holds one accepted beat until the parser consumes it.
`default_nettype none
module dfr_in_stage (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  dfr_pkg::dfr_in_t in_beat,
  input  wire              advance,
  output logic             beat_valid,
  output dfr_pkg::dfr_in_t beat
);

  logic             valid_r;
  dfr_pkg::dfr_in_t beat_r;

  // room when empty or when the held beat moves on this cycle
  assign in_ready   = !valid_r || advance;
  assign beat_valid = valid_r;
  assign beat       = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

endmodule
`default_nettype wire

FILE: src/dfr_parse.sv
// Frame parser: phase and length state plus the one-beat update.
`default_nettype none
module dfr_parse (
  input  wire               clk,
  input  wire               rst_n,
  input  dfr_pkg::dfr_in_t  beat,
  input  wire               step_en,
  output logic              res_valid,
  output dfr_pkg::dfr_out_t res
);

  // parser phases
  localparam logic [2:0] PH_SKIP_NAME = 3'd0;
  localparam logic [2:0] PH_NAME_LEN  = 3'd1;
  localparam logic [2:0] PH_NAME      = 3'd2;
  localparam logic [2:0] PH_SEPARATOR = 3'd3;
  localparam logic [2:0] PH_SKIP_DATA = 3'd4;
  localparam logic [2:0] PH_DATA_LEN  = 3'd5;
  localparam logic [2:0] PH_DATA      = 3'd6;

  logic [2:0]               phase_r, phase_nxt;
  logic [dfr_pkg::LEN_W-1:0] acc_r, acc_nxt;
  logic [dfr_pkg::LEN_W-1:0] rem_r, rem_nxt;

  logic [7:0]                b;
  logic                      is_digit;
  logic [dfr_pkg::LEN_W-1:0] dig_ext;
  logic [dfr_pkg::LEN_W-1:0] acc_step;
  logic [dfr_pkg::LEN_W-1:0] rem_dec;

  assign b        = beat.in_byte;
  assign is_digit = b inside {[dfr_pkg::CH_ZERO:dfr_pkg::CH_NINE]};
  // digit value is the low nibble of '0'..'9'
  assign dig_ext  = dfr_pkg::LEN_W'(b[3:0]);
  // acc * 10 + digit, as two shifts and adds
  assign acc_step = (acc_r << 3) + (acc_r << 1) + dig_ext;
  assign rem_dec  = rem_r - dfr_pkg::LEN_W'(1);

  // next state and result for the current beat
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    res_valid = 1'b0;
    res       = '0;
    if (beat.link_closed) begin
      // close only matters while data bytes are due
      if (phase_r == PH_DATA) begin
        phase_nxt = PH_SKIP_NAME;
        acc_nxt   = '0;
        rem_nxt   = '0;
        res_valid = 1'b1;
        res.kind  = dfr_pkg::KIND_CLOSED;
      end
    end else begin
      case (phase_r)
        PH_NAME_LEN, PH_DATA_LEN: begin
          if (is_digit) begin
            acc_nxt = acc_step;
          end else begin
            rem_nxt = acc_r;
            acc_nxt = '0;
            if (acc_r == '0) begin
              if (phase_r == PH_DATA_LEN) begin
                phase_nxt = PH_SKIP_NAME;
                rem_nxt   = '0;
                res_valid = 1'b1;
                res.kind  = dfr_pkg::KIND_EMPTY;
              end else begin
                phase_nxt = PH_SEPARATOR;
              end
            end else begin
              phase_nxt = (phase_r == PH_DATA_LEN) ? PH_DATA : PH_NAME;
            end
          end
        end
        PH_NAME, PH_DATA: begin
          rem_nxt      = rem_dec;
          res_valid    = 1'b1;
          res.kind     = (phase_r == PH_DATA) ? dfr_pkg::KIND_DATA : dfr_pkg::KIND_NAME;
          res.out_byte = b;
          res.last     = (rem_r == dfr_pkg::LEN_W'(1));
          if (rem_dec == '0) begin
            if (phase_r == PH_DATA) begin
              phase_nxt = PH_SKIP_NAME;
              acc_nxt   = '0;
            end else begin
              phase_nxt = PH_SEPARATOR;
            end
          end
        end
        PH_SEPARATOR: begin
          phase_nxt = PH_SKIP_DATA;
        end
        default: begin
          // skip phases; the unused code behaves as the name skip phase
          if (b == dfr_pkg::CH_NEWLINE) begin
            phase_nxt = phase_r;
          end else if (is_digit) begin
            acc_nxt   = dig_ext;
            phase_nxt = (phase_r == PH_SKIP_DATA) ? PH_DATA_LEN : PH_NAME_LEN;
          end else if (phase_r == PH_SKIP_DATA) begin
            // non-digit ends the data length at zero
            phase_nxt = PH_SKIP_NAME;
            acc_nxt   = '0;
            rem_nxt   = '0;
            res_valid = 1'b1;
            res.kind  = dfr_pkg::KIND_EMPTY;
          end else begin
            // non-digit ends the name length at zero
            phase_nxt = PH_SEPARATOR;
            acc_nxt   = '0;
            rem_nxt   = '0;
          end
        end
      endcase
    end
  end

  // state update once per consumed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP_NAME;
      acc_r   <= '0;
      rem_r   <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/dfr_out_stage.sv
// Result register: holds one result beat until the consumer takes it.
`default_nettype none
module dfr_out_stage (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               load,
  input  dfr_pkg::dfr_out_t res,
  output logic              slot_free,
  output logic              out_valid,
  input  wire               out_ready,
  output dfr_pkg::dfr_out_t out_beat
);

  logic              valid_r;
  dfr_pkg::dfr_out_t beat_r;

  assign slot_free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_beat  = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= res;
    end
  end

endmodule
`default_nettype wire

FILE: src/ascii_length_prefixed_deframer.sv
// Top level of the ASCII length-prefixed deframer.
//
//   channel | ports                          | direction | beat
//   --------+--------------------------------+-----------+-------------------------------
//   in      | in_valid, in_ready, in_beat    | input     | one stream byte or link close
//   out     | out_valid, out_ready, out_beat | output    | name/data byte or frame marker
//
// One byte per cycle sustained unless a result waits on a full output register; out_valid is registered.
// The input register feeds the parser, whose result lands in the output register.
// A beat that yields no result moves on even while the output register is full.
// rst_n is synchronous; after reset the parser skips newlines before a name length.
// in_ready drops only when a held beat has a result and the output register stays full.
`default_nettype none
module ascii_length_prefixed_deframer (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  dfr_pkg::dfr_in_t  in_beat,
  output logic              out_valid,
  input  wire               out_ready,
  output dfr_pkg::dfr_out_t out_beat
);

  logic              beat_valid;
  dfr_pkg::dfr_in_t  beat;
  logic              res_valid;
  dfr_pkg::dfr_out_t res;
  logic              slot_free;
  logic              advance;

  // held beat moves on if it has no result or the output slot can take it
  assign advance = beat_valid && (slot_free || !res_valid);

  dfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .advance    (advance),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  dfr_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .step_en   (advance),
    .res_valid (res_valid),
    .res       (res)
  );

  dfr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

endmodule
`default_nettype wire
